// ===== rtl/fcbf_pkg.sv =====
// Package for the free class bitmap finder: sizes, command codes and the
// memory request structure. No dependencies.
`default_nettype none

package fcbf_pkg;

   // Index geometry
   localparam int NUM_CLASSES = 512;
   localparam int WORD_BITS   = 32;
   localparam int NUM_WORDS   = (NUM_CLASSES + WORD_BITS - 1) / WORD_BITS;
   localparam int CLASS_W     = $clog2(NUM_CLASSES);
   localparam int BIT_IDX_W   = $clog2(WORD_BITS);
   localparam int WORD_IDX_W  = $clog2(NUM_WORDS);

   // Field widths fixed by the interface
   localparam int CMD_W     = 2;
   localparam int REQUEST_W = 24;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_MARK_FULL  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_MARK_EMPTY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FIND       = 2'd2;

   // Access to the class bitmap memory
   typedef struct packed {
      logic                  rd_en;
      logic [WORD_IDX_W-1:0] rd_addr;
      logic                  wr_en;
      logic [WORD_IDX_W-1:0] wr_addr;
      logic [WORD_BITS-1:0]  wr_data;
   } fcbf_ram_req_type;

endpackage

`default_nettype wire

// ===== rtl/free_class_bitmap_finder_unit.sv =====
// Free class bitmap finder: a class occupancy index for a segregated free
// list allocator. A mark transaction issues the memory read in the accepting
// cycle and the write back in the cycle after, and busy stays high through
// the write back. A find keeps busy high until it has its result. Each
// candidate word costs a summary select step plus a memory read. At most
// three words are read: the lowest non-empty one from the request's word up,
// possibly the next word with its first class excluded, then an unmasked
// word that always hits. One more select step is spent when the scan runs
// out of non-empty words; a find on an empty index takes only that step.
// The find result strobes on rsp_valid for one cycle as busy falls; the
// receiver cannot stall it. Command 3 is accepted and does nothing.
// Depends on fcbf_pkg, fcbf_class_ram and fcbf_word_scan.
`default_nettype none

module free_class_bitmap_finder_unit
   import fcbf_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic [CMD_W-1:0]     req_cmd,
   input  wire logic [CLASS_W-1:0]   req_class_index,
   input  wire logic [REQUEST_W-1:0] req_request_words,
   output logic                      rsp_valid,
   output logic                      rsp_found,
   output logic [CLASS_W-1:0]        rsp_found_class
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MARK_WR,
      ST_FIND_SEL,
      ST_FIND_CHK
   } state_type;

   state_type             state_ff,     state_in;
   logic [CMD_W-1:0]      cmd_ff,       cmd_in;
   logic [CLASS_W-1:0]    cls_ff,       cls_in;
   logic [WORD_IDX_W-1:0] scan_ff,      scan_in;
   logic [WORD_IDX_W-1:0] cur_ff,       cur_in;
   logic [NUM_WORDS-1:0]  summary_ff,   summary_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_found_ff, rsp_found_in;
   logic [CLASS_W-1:0]    rsp_class_ff, rsp_class_in;

   fcbf_ram_req_type      ram_req;
   logic [WORD_BITS-1:0]  rd_data;
   logic [WORD_BITS-1:0]  cur_word;
   logic [WORD_BITS-1:0]  new_word;
   logic [WORD_IDX_W-1:0] cls_word;
   logic [BIT_IDX_W-1:0]  cls_bit;
   logic [CLASS_W-1:0]    req_r;
   logic                  sel_hit;
   logic [WORD_IDX_W-1:0] sel_idx;
   logic                  scan_hit;
   logic [BIT_IDX_W-1:0]  scan_bit;
   logic                  accept;

   fcbf_class_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   fcbf_word_scan u_scan (
      .word_data (rd_data),
      .word_idx  (cur_ff),
      .req_class (cls_ff),
      .hit       (scan_hit),
      .bit_idx   (scan_bit)
   );

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // Size to class: zero behaves as one, oversize goes to the catch-all
   always_comb begin
      if (req_request_words == '0) begin
         req_r = '0;
      end else if (req_request_words > REQUEST_W'(NUM_CLASSES)) begin
         req_r = CLASS_W'(NUM_CLASSES - 1);
      end else begin
         req_r = CLASS_W'(req_request_words - REQUEST_W'(1));
      end
   end

   // Lowest non-empty word at or above the scan start
   always_comb begin
      sel_hit = 1'b0;
      sel_idx = '0;
      for (int i = NUM_WORDS - 1; i >= 0; i--) begin
         if (summary_ff[i] && (WORD_IDX_W'(i) >= scan_ff)) begin
            sel_hit = 1'b1;
            sel_idx = WORD_IDX_W'(i);
         end
      end
   end

   // Read-modify-write of a marked word; a word whose summary bit is clear
   // is all zero, so unwritten memory is never used
   assign cls_word = cls_ff[CLASS_W-1 -: WORD_IDX_W];
   assign cls_bit  = cls_ff[BIT_IDX_W-1:0];
   assign cur_word = summary_ff[cls_word] ? rd_data : '0;

   always_comb begin
      if (cmd_ff == CMD_MARK_FULL) begin
         new_word = cur_word | (WORD_BITS'(1) << cls_bit);
      end else begin
         new_word = cur_word & ~(WORD_BITS'(1) << cls_bit);
      end
   end

   // Next state, memory access and result
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      cls_in       = cls_ff;
      scan_in      = scan_ff;
      cur_in       = cur_ff;
      summary_in   = summary_ff;
      rsp_valid_in = 1'b0;
      rsp_found_in = rsp_found_ff;
      rsp_class_in = rsp_class_ff;
      ram_req      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in = req_cmd;
               if (req_cmd == CMD_MARK_FULL || req_cmd == CMD_MARK_EMPTY) begin
                  cls_in          = req_class_index;
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = req_class_index[CLASS_W-1 -: WORD_IDX_W];
                  state_in        = ST_MARK_WR;
               end else if (req_cmd == CMD_FIND) begin
                  cls_in   = req_r;
                  scan_in  = req_r[CLASS_W-1 -: WORD_IDX_W];
                  state_in = ST_FIND_SEL;
               end
            end
         end
         ST_MARK_WR: begin
            ram_req.wr_en   = 1'b1;
            ram_req.wr_addr = cls_word;
            ram_req.wr_data = new_word;
            summary_in[cls_word] = (cmd_ff == CMD_MARK_FULL) ? 1'b1 : (|new_word);
            state_in        = ST_IDLE;
         end
         ST_FIND_SEL: begin
            if (sel_hit) begin
               ram_req.rd_en   = 1'b1;
               ram_req.rd_addr = sel_idx;
               cur_in          = sel_idx;
               state_in        = ST_FIND_CHK;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b0;
               rsp_class_in = '0;
               state_in     = ST_IDLE;
            end
         end
         ST_FIND_CHK: begin
            if (scan_hit) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b1;
               rsp_class_in = {cur_ff, scan_bit};
               state_in     = ST_IDLE;
            end else if (cur_ff == WORD_IDX_W'(NUM_WORDS - 1)) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = 1'b0;
               rsp_class_in = '0;
               state_in     = ST_IDLE;
            end else begin
               scan_in  = cur_ff + WORD_IDX_W'(1);
               state_in = ST_FIND_SEL;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         summary_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_found_ff <= 1'b0;
         rsp_class_ff <= '0;
      end else begin
         state_ff     <= state_in;
         summary_ff   <= summary_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_found_ff <= rsp_found_in;
         rsp_class_ff <= rsp_class_in;
      end
      cmd_ff  <= cmd_in;
      cls_ff  <= cls_in;
      scan_ff <= scan_in;
      cur_ff  <= cur_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_found_class = rsp_class_ff;

`ifndef NO_ASSERTIONS
   // A result only closes a find that was in progress
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy) && !busy)
      else $error("result strobe without a find in progress");

   // A miss always reports class zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_found_class == '0))
      else $error("miss with non-zero class");

   // Memory is written only on the write-back cycle of a mark
   a_wr_in_mark: assert property (@(posedge clock) disable iff (reset)
      ram_req.wr_en |-> (state_ff == ST_MARK_WR) && !ram_req.rd_en)
      else $error("memory write outside mark write-back");

   // Marking a class non-empty leaves its summary bit set
   a_summary_set: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK_WR && cmd_ff == CMD_MARK_FULL) |=>
         summary_ff[$past(cls_word)])
      else $error("summary bit not set after marking a class non-empty");
`endif

endmodule

`default_nettype wire

// ===== rtl/fcbf_class_ram.sv =====
// Class bitmap memory: one word of occupancy bits per row, one write and
// one registered read per cycle. Depends on fcbf_pkg.
`default_nettype none

module fcbf_class_ram
   import fcbf_pkg::*;
(
   input  wire logic                 clock,
   input  wire fcbf_ram_req_type     ram_req,
   output logic [WORD_BITS-1:0]      rd_data
);

   logic [WORD_BITS-1:0] mem [NUM_WORDS];
   logic [WORD_BITS-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/fcbf_word_scan.sv =====
// Masks one bitmap word against the requested class (classes below it and
// the excluded next class) and finds the lowest remaining bit. Uses fcbf_pkg.
`default_nettype none

module fcbf_word_scan
   import fcbf_pkg::*;
(
   input  wire logic [WORD_BITS-1:0]  word_data,
   input  wire logic [WORD_IDX_W-1:0] word_idx,
   input  wire logic [CLASS_W-1:0]    req_class,
   output logic                       hit,
   output logic [BIT_IDX_W-1:0]       bit_idx
);

   logic [WORD_BITS-1:0] eligible;
   logic [CLASS_W:0]     skip_class;

   assign skip_class = {1'b0, req_class} + (CLASS_W+1)'(1);

   // Per-bit eligibility: at or above the request, next class skipped
   // unless it is the catch-all class
   always_comb begin
      logic [CLASS_W-1:0] cls;
      for (int b = 0; b < WORD_BITS; b++) begin
         cls = {word_idx, BIT_IDX_W'(b)};
         eligible[b] = word_data[b] && (cls >= req_class) &&
                       !(({1'b0, cls} == skip_class) &&
                         (cls != CLASS_W'(NUM_CLASSES - 1)));
      end
   end

   // Lowest set bit
   always_comb begin
      hit     = 1'b0;
      bit_idx = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (eligible[b]) begin
            hit     = 1'b1;
            bit_idx = BIT_IDX_W'(b);
         end
      end
   end

endmodule

`default_nettype wire
